// ===== hw/rtl/sorted_deadline_timer_queue_defines.svh =====
// Assertion macros used by the timer queue checker.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define STDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define STDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/stdq_pkg.sv =====
// Types, constants and helpers shared by the timer queue modules.
package stdq_pkg;

    localparam int unsigned DEPTH = 16;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    localparam logic [30:0] IDLE_WAIT_RESET = 31'd2000;
    localparam logic [30:0] WAIT_MAX        = {31{1'b1}};

    // Result kinds
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_WAIT    = 2'd2;

    // Add status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_WAKE = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // Input opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic [31:0] deadline;
        logic [31:0] id;
        logic [31:0] tag;
    } t_entry;

    typedef struct packed {
        logic [31:0] sum;
        logic        zero;
        logic        msb;
    } t_alu_res;

    // Map a list position to a slot of the circular buffer.
    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                              input logic [CNT_W-1:0] ofs);
        logic [PTR_W:0] s;
        s = {1'b0, head} + ofs;
        if (s >= (PTR_W+1)'(DEPTH))
            s = s - (PTR_W+1)'(DEPTH);
        return s[PTR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/stdq_entry_ram.sv =====
// Timer entry store: one write port, one registered read port.
module stdq_entry_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [stdq_pkg::PTR_W-1:0]  i_waddr,
    input  stdq_pkg::t_entry            i_wdata,
    input  logic [stdq_pkg::PTR_W-1:0]  i_raddr,
    output stdq_pkg::t_entry            o_rdata
);

    stdq_pkg::t_entry r_mem [stdq_pkg::DEPTH];
    stdq_pkg::t_entry r_rdata;

    // Write one slot and register one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/stdq_alu.sv =====
// Shared 32-bit add/subtract unit with zero and sign flags.
module stdq_alu (
    input  logic [31:0]        i_a,
    input  logic [31:0]        i_b,
    input  logic               i_sub,
    output stdq_pkg::t_alu_res o_res
);

    logic [31:0] w_b;
    logic [31:0] w_sum;

    // Invert and carry in for subtract
    assign w_b   = i_sub ? ~i_b : i_b;
    assign w_sum = i_a + w_b + 32'(i_sub);

    assign o_res.sum  = w_sum;
    assign o_res.zero = (w_sum == 32'd0);
    assign o_res.msb  = w_sum[31];

endmodule

// ===== hw/rtl/sorted_deadline_timer_queue.sv =====
// Top level: deadline-sorted timer list with millisecond time base.
//
// Commands are taken when start is high and busy is low; results appear for
// one cycle each on o_result_valid and cannot be held off by the receiver.
// An add moves each later entry up one slot in turn and acknowledges
// with wake status when it lands at the head, or with OK status when it
// stops behind an earlier or equal entry; an add to a full list is
// acknowledged the cycle after accept. A tick reports each expired timer
// in turn, then the remaining wait (the idle wait on an empty list).
// The pace is set by the single-read-port entry memory, whose read data
// is registered, and by the one shared subtractor that does every deadline
// compare. The entry memory needs no clearing after reset: only slots below
// the fill count are ever read. The idle wait register is written only while
// busy is low.
module sorted_deadline_timer_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [30:0] i_interval_ms,
    input  logic [31:0] i_callback_tag,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_idle_wait_ms,
    output logic        o_result_valid,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [31:0] o_timer_id,
    output logic [31:0] o_expired_tag,
    output logic [30:0] o_wait_ms,
    output logic        o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_EXP_RD,
        S_EXP_CMP,
        S_WAIT
    } t_state;

    t_state                       r_state;
    logic [31:0]                  r_now;
    logic [31:0]                  r_id;
    logic [30:0]                  r_idle_wait;
    logic [stdq_pkg::CNT_W-1:0]   r_count;
    logic [stdq_pkg::PTR_W-1:0]   r_head;
    logic [stdq_pkg::CNT_W-1:0]   r_j;
    logic [31:0]                  r_dl;
    logic [31:0]                  r_tag;

    logic                         r_out_valid;
    logic [1:0]                   r_kind;
    logic [1:0]                   r_status;
    logic [31:0]                  r_timer_id;
    logic [31:0]                  r_expired_tag;
    logic [30:0]                  r_wait_ms;
    logic                         r_last;

    logic                         w_we;
    logic [stdq_pkg::PTR_W-1:0]   w_waddr;
    stdq_pkg::t_entry             w_wdata;
    logic [stdq_pkg::PTR_W-1:0]   w_raddr;
    stdq_pkg::t_entry             w_rdata;
    stdq_pkg::t_entry             w_new;
    logic [31:0]                  w_alu_a;
    logic [31:0]                  w_alu_b;
    logic                         w_alu_sub;
    stdq_pkg::t_alu_res           w_alu;
    logic                         w_later;
    logic                         w_accept;
    logic                         w_full;
    logic [30:0]                  w_wait;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_accept    = start && !busy;
    assign w_full      = (r_count == stdq_pkg::CNT_W'(stdq_pkg::DEPTH));

    assign w_new.deadline = r_dl;
    assign w_new.id       = r_id;
    assign w_new.tag      = r_tag;

    // Stored entry strictly later than the new deadline
    assign w_later = !w_alu.zero && !w_alu.msb;

    // Clamp the remaining wait to 31 bits and to at least one
    always_comb begin
        if (w_alu.msb)
            w_wait = stdq_pkg::WAIT_MAX;
        else if (w_alu.sum[30:0] == 31'd0)
            w_wait = 31'd1;
        else
            w_wait = w_alu.sum[30:0];
    end

    // Steer the shared unit and the entry memory
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = stdq_pkg::phys(r_head, r_j);
        w_wdata   = w_new;
        w_raddr   = stdq_pkg::phys(r_head, r_j - stdq_pkg::CNT_W'(1));
        w_alu_a   = r_now;
        w_alu_b   = {1'b0, i_interval_ms};
        w_alu_sub = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_alu_a   = r_now;
                w_alu_b   = {1'b0, i_interval_ms};
                w_alu_sub = 1'b0;
            end
            S_INS_RD: begin
                w_we = (r_j == '0);
            end
            S_INS_CMP: begin
                w_alu_a   = w_rdata.deadline;
                w_alu_b   = r_dl;
                w_alu_sub = 1'b1;
                w_we      = 1'b1;
                w_wdata   = w_later ? w_rdata : w_new;
            end
            S_EXP_RD: begin
                w_raddr = r_head;
            end
            S_EXP_CMP: begin
                // Hold the head on the read port for the wait report
                w_raddr   = r_head;
                w_alu_a   = r_now;
                w_alu_b   = w_rdata.deadline;
                w_alu_sub = 1'b1;
            end
            S_WAIT: begin
                w_alu_a   = w_rdata.deadline;
                w_alu_b   = r_now;
                w_alu_sub = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    stdq_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    stdq_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .i_sub (w_alu_sub),
        .o_res (w_alu)
    );

    // Sequencer, list state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_id        <= '0;
            r_idle_wait <= stdq_pkg::IDLE_WAIT_RESET;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid   <= 1'b0;
            r_kind        <= stdq_pkg::KIND_ACK;
            r_status      <= stdq_pkg::STATUS_OK;
            r_timer_id    <= '0;
            r_expired_tag <= '0;
            r_wait_ms     <= '0;
            r_last        <= 1'b1;

            if (i_cfg_valid && o_cfg_ready) begin
                r_idle_wait <= i_cfg_idle_wait_ms;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_opcode == stdq_pkg::OP_TICK) begin
                            r_now   <= r_now + 32'd1;
                            r_state <= S_EXP_RD;
                        end else if (w_full) begin
                            r_out_valid <= 1'b1;
                            r_status    <= stdq_pkg::STATUS_FULL;
                        end else begin
                            r_dl    <= w_alu.sum;
                            r_tag   <= i_callback_tag;
                            r_id    <= r_id + 32'd1;
                            r_j     <= r_count;
                            r_state <= S_INS_RD;
                        end
                    end
                end
                S_INS_RD: begin
                    if (r_j == '0) begin
                        // New timer lands at the head
                        r_count     <= r_count + stdq_pkg::CNT_W'(1);
                        r_out_valid <= 1'b1;
                        r_status    <= stdq_pkg::STATUS_WAKE;
                        r_timer_id  <= r_id;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (w_later) begin
                        // Shift the later entry up one slot and keep looking
                        r_j     <= r_j - stdq_pkg::CNT_W'(1);
                        r_state <= S_INS_RD;
                    end else begin
                        r_count     <= r_count + stdq_pkg::CNT_W'(1);
                        r_out_valid <= 1'b1;
                        r_status    <= stdq_pkg::STATUS_OK;
                        r_timer_id  <= r_id;
                        r_state     <= S_IDLE;
                    end
                end
                S_EXP_RD: begin
                    if (r_count == '0) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= stdq_pkg::KIND_WAIT;
                        r_wait_ms   <= r_idle_wait;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_EXP_CMP;
                    end
                end
                S_EXP_CMP: begin
                    if (!w_alu.msb) begin
                        // Head has expired: emit and drop it
                        r_out_valid   <= 1'b1;
                        r_kind        <= stdq_pkg::KIND_EXPIRED;
                        r_timer_id    <= w_rdata.id;
                        r_expired_tag <= w_rdata.tag;
                        r_last        <= 1'b0;
                        r_head        <= stdq_pkg::phys(r_head, stdq_pkg::CNT_W'(1));
                        r_count       <= r_count - stdq_pkg::CNT_W'(1);
                        r_state       <= S_EXP_RD;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_out_valid <= 1'b1;
                    r_kind      <= stdq_pkg::KIND_WAIT;
                    r_wait_ms   <= w_wait;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_kind         = r_kind;
    assign o_status       = r_status;
    assign o_timer_id     = r_timer_id;
    assign o_expired_tag  = r_expired_tag;
    assign o_wait_ms      = r_wait_ms;
    assign o_last         = r_last;

endmodule

// ===== hw/rtl/stdq_checker.sv =====
// Port-level checker for the timer queue, bound to the top level.
`include "sorted_deadline_timer_queue_defines.svh"

module stdq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_valid,
    input logic [1:0]  o_kind,
    input logic [1:0]  o_status,
    input logic [31:0] o_timer_id,
    input logic        o_last
);

    // Final beat of a command leaves the block ready
    `STDQ_ASSERT_NOW(a_last_frees, o_result_valid && o_last, !busy, "busy after final beat")

    // Only expiries are followed by more beats
    `STDQ_ASSERT_NOW(a_mid_is_expiry, o_result_valid && !o_last, o_kind == stdq_pkg::KIND_EXPIRED, "non-final beat is not an expiry")

    // Expiry and wait beats carry no add status
    `STDQ_ASSERT_NOW(a_status_zero, o_result_valid && o_kind != stdq_pkg::KIND_ACK, o_status == stdq_pkg::STATUS_OK, "status set outside add ack")

    // A rejected add hands out no id
    `STDQ_ASSERT_NOW(a_full_no_id, o_result_valid && o_kind == stdq_pkg::KIND_ACK && o_status == stdq_pkg::STATUS_FULL, o_timer_id == 32'd0, "full ack carries an id")

    // No beat appears unless a command was taken or is in progress
    `STDQ_ASSERT_NEXT(a_no_spurious, !busy && !start, !o_result_valid, "beat without a command")

endmodule

bind sorted_deadline_timer_queue stdq_checker u_stdq_checker (.*);
